// File: rtl/tek_pkg.sv
// Shared types, event codes and command/status bundles of the touch event translator.
`default_nettype none
package tek_pkg;
   localparam int MaxKeys = 16;
   localparam int KeyIdxW = 4;
   localparam int ProdW   = 47;
   localparam int QuoW    = 48;
   localparam int DivCntW = 6;

   localparam logic [15:0] EV_SYN = 16'h0000;
   localparam logic [15:0] EV_KEY = 16'h0001;
   localparam logic [15:0] EV_REL = 16'h0002;
   localparam logic [15:0] EV_ABS = 16'h0003;

   localparam logic [15:0] CODE_REPORT   = 16'h0000;
   localparam logic [15:0] CODE_MT_SYNC  = 16'h0002;
   localparam logic [15:0] CODE_REL_Z    = 16'h0002;
   localparam logic [15:0] CODE_ABS_X    = 16'h0000;
   localparam logic [15:0] CODE_ABS_Y    = 16'h0001;
   localparam logic [15:0] CODE_ALT_RPT  = 16'h002a;
   localparam logic [15:0] CODE_TOUCH_MJ = 16'h0030;
   localparam logic [15:0] CODE_MT_X     = 16'h0035;
   localparam logic [15:0] CODE_MT_Y     = 16'h0036;
   localparam logic [15:0] CODE_MT_SLOT  = 16'h0039;
   localparam logic [15:0] CODE_PRESSURE = 16'h003a;

   localparam logic [15:0] OUT_CODE_RELEASE = 16'h0000;
   localparam logic [15:0] OUT_CODE_POS     = 16'h0001;

   localparam logic [2:0] REG_ST_X   = 3'd0;
   localparam logic [2:0] REG_ST_Y   = 3'd1;
   localparam logic [2:0] REG_MT_X   = 3'd2;
   localparam logic [2:0] REG_MT_Y   = 3'd3;
   localparam logic [2:0] REG_WIDTH  = 3'd4;
   localparam logic [2:0] REG_HEIGHT = 3'd5;
   localparam logic [2:0] REG_ORIENT = 3'd6;
   localparam logic [2:0] REG_KEYS   = 3'd7;

   localparam logic [1:0] CLS_DONE  = 2'd0;
   localparam logic [1:0] CLS_EMIT  = 2'd1;
   localparam logic [1:0] CLS_SCALE = 2'd2;
   localparam logic [1:0] CLS_RAW   = 2'd3;

   typedef struct packed {
      logic [31:0] st_x_axis;
      logic [31:0] st_y_axis;
      logic [31:0] mt_x_axis;
      logic [31:0] mt_y_axis;
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [2:0]  orient_mode;
      logic [4:0]  key_count;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic axis_y;
      logic mul;
      logic load;
      logic div_step;
      logic store;
      logic post;
      logic scan_clear;
      logic scan_read;
      logic scan_next;
      logic key_hit;
      logic take_pos;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       div_done;
      logic       out_free;
      logic       no_pos;
      logic       scan_needed;
      logic       hit;
      logic       scan_last;
      logic       discard;
   } status_type;
endpackage
`default_nettype wire

// File: rtl/tek_ctrl.sv
// Sequencer that steps one event word through decode, scaling, key scan and output.
`default_nettype none
module tek_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire tek_pkg::status_type status,
   output tek_pkg::cmd_type        cmd
);
   import tek_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_LOAD   = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_POST   = 4'd5;
   localparam logic [3:0] S_CHECK  = 4'd6;
   localparam logic [3:0] S_SADDR  = 4'd7;
   localparam logic [3:0] S_SCHK   = 4'd8;
   localparam logic [3:0] S_FINAL  = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       axis_ff, axis_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis_y = axis_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.apply = 1'b1;
            axis_in   = 1'b0;
            case (status.cls)
               CLS_EMIT:  state_in = S_EMIT;
               CLS_SCALE: state_in = S_MUL;
               CLS_RAW:   state_in = S_POST;
               default:   state_in = S_IDLE;
            endcase
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.store = 1'b1;
               axis_in   = 1'b1;
               state_in  = axis_ff ? S_POST : S_MUL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_POST: begin
            cmd.post = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.no_pos) begin
               state_in = S_IDLE;
            end else if (status.scan_needed) begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SADDR;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_SADDR: begin
            cmd.scan_read = 1'b1;
            state_in      = S_SCHK;
         end
         S_SCHK: begin
            if (status.hit) begin
               cmd.key_hit = 1'b1;
               state_in    = S_EMIT;
            end else if (status.scan_last) begin
               state_in = S_FINAL;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SADDR;
            end
         end
         S_FINAL: begin
            if (status.discard) begin
               state_in = S_IDLE;
            end else begin
               cmd.take_pos = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/tek_dp.sv
// Datapath: event state, scaling multiplier and divider, key table and output register.
`default_nettype none
module tek_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tek_pkg::cfg_type    cfg,
   input  wire tek_pkg::cmd_type    cmd,
   output tek_pkg::status_type      status,
   input  wire logic                req_op,
   input  wire logic [15:0]         req_ev_type,
   input  wire logic [15:0]         req_ev_code,
   input  wire logic signed [31:0]  req_ev_value,
   input  wire logic [3:0]          req_key_index,
   input  wire logic [15:0]         req_key_scancode,
   input  wire logic [15:0]         req_key_center_x,
   input  wire logic [15:0]         req_key_center_y,
   input  wire logic [15:0]         req_key_width,
   input  wire logic [15:0]         req_key_height,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [15:0]              rsp_out_type,
   output logic [15:0]              rsp_out_code,
   output logic signed [31:0]       rsp_out_value
);
   import tek_pkg::*;

   logic               op_ff;
   logic [15:0]        type_ff, code_ff;
   logic signed [31:0] value_ff;
   logic [3:0]         kidx_ff;
   logic [15:0]        kcode_ff, kcx_ff, kcy_ff, kw_ff, kh_ff;

   logic               ignored_ff, discard_ff, lwr_ff, rp_ff;
   logic               st_any_ff, mt_any_ff, slot_zero_ff;
   logic signed [16:0] down_x_ff, down_y_ff;
   logic signed [31:0] st_x_ff, st_y_ff, mt_x_ff, mt_y_ff;

   logic signed [31:0] px_ff, py_ff;
   logic [31:0]        xa_ff, ya_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic [ProdW-1:0]   quo_ff;
   logic [17:0]        rem_ff;
   logic [16:0]        den_ff;
   logic               qneg_ff;
   logic [DivCntW-1:0] cnt_ff;
   logic signed [QuoW-1:0] qx_ff, qy_ff;
   logic signed [16:0] sx_ff, sy_ff;

   logic [79:0]        mem [MaxKeys];
   logic [79:0]        rd_ff;
   logic [KeyIdxW-1:0] idx_ff;

   logic [15:0]        stg_type_ff, stg_code_ff;
   logic [31:0]        stg_value_ff;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_type_ff, rsp_code_ff;
   logic [31:0]        rsp_value_ff;

   logic t2c2, t1v0, is_abs, is_pass, sel_st, eq_axes;
   logic [31:0] xa_sel, ya_sel;
   logic [1:0]  cls;

   always_comb begin
      t2c2    = (type_ff == EV_REL) && (code_ff == CODE_REL_Z);
      t1v0    = (type_ff == EV_KEY) && (value_ff == 32'sd0);
      is_abs  = (type_ff == EV_ABS);
      is_pass = (code_ff != CODE_ALT_RPT) &&
                ((type_ff != EV_SYN) ||
                 ((code_ff != CODE_REPORT) && (code_ff != CODE_MT_SYNC)));
      sel_st  = st_any_ff;
      xa_sel  = sel_st ? cfg.st_x_axis : cfg.mt_x_axis;
      ya_sel  = sel_st ? cfg.st_y_axis : cfg.mt_y_axis;
      eq_axes = (xa_sel[15:0] == xa_sel[31:16]) || (ya_sel[15:0] == ya_sel[31:16]);
      if (op_ff || ignored_ff || t2c2 || t1v0 || is_abs) begin
         cls = CLS_DONE;
      end else if (is_pass || (code_ff == CODE_MT_SYNC)) begin
         cls = CLS_EMIT;
      end else if (lwr_ff || rp_ff) begin
         cls = discard_ff ? CLS_DONE : CLS_EMIT;
      end else if (st_any_ff || mt_any_ff) begin
         cls = eq_axes ? CLS_RAW : CLS_SCALE;
      end else begin
         cls = CLS_DONE;
      end
   end

   // scaling operands for the current axis
   logic signed [31:0] pos_a;
   logic [31:0]        ax_a;
   logic [12:0]        size_a;
   logic signed [33:0] diff_a;
   logic signed [13:0] sizem1_a;
   logic signed [17:0] den_s;
   always_comb begin
      pos_a  = cmd.axis_y ? py_ff : px_ff;
      ax_a   = cmd.axis_y ? ya_ff : xa_ff;
      if (cmd.axis_y) begin
         size_a = cfg.orient_mode[0] ? cfg.screen_width : cfg.screen_height;
      end else begin
         size_a = cfg.orient_mode[0] ? cfg.screen_height : cfg.screen_width;
      end
      diff_a   = 34'(pos_a) - 34'($signed(ax_a[15:0]));
      sizem1_a = $signed({1'b0, size_a}) - 14'sd1;
      den_s    = 18'($signed(ax_a[31:16])) - 18'($signed(ax_a[15:0]));
   end

   logic [17:0] trial;
   logic        tge;
   always_comb begin
      trial = {rem_ff[16:0], quo_ff[ProdW-1]};
      tge   = (trial >= {1'b0, den_ff});
   end

   // orientation and saturation
   logic signed [QuoW:0] x0, y0, x1, y1;
   logic signed [16:0]   sx_n, sy_n;
   always_comb begin
      x0 = cfg.orient_mode[0] ? (QuoW+1)'(qy_ff) : (QuoW+1)'(qx_ff);
      y0 = cfg.orient_mode[0] ? (QuoW+1)'(qx_ff) : (QuoW+1)'(qy_ff);
      x1 = cfg.orient_mode[1] ? ($signed({1'b0, cfg.screen_width}) - x0) : x0;
      y1 = cfg.orient_mode[2] ? ($signed({1'b0, cfg.screen_height}) - y0) : y0;
      if (x1 < -(QuoW+1)'(65536))     sx_n = -17'sd65536;
      else if (x1 > (QuoW+1)'(65535)) sx_n = 17'sd65535;
      else                            sx_n = x1[16:0];
      if (y1 < -(QuoW+1)'(65536))     sy_n = -17'sd65536;
      else if (y1 > (QuoW+1)'(65535)) sy_n = 17'sd65535;
      else                            sy_n = y1[16:0];
   end

   // key hit test
   logic [4:0]         n_eff;
   logic signed [17:0] dx, dy;
   logic [17:0]        adx, ady;
   logic               hit;
   always_comb begin
      n_eff = (cfg.key_count > 5'(MaxKeys)) ? 5'(MaxKeys) : cfg.key_count;
      dx    = $signed({2'b0, rd_ff[31:16]}) - 18'(sx_ff);
      dy    = $signed({2'b0, rd_ff[47:32]}) - 18'(sy_ff);
      adx   = dx[17] ? 18'(-dx) : 18'(dx);
      ady   = dy[17] ? 18'(-dy) : 18'(dy);
      hit   = (adx < {3'b0, rd_ff[63:49]}) && (ady < {3'b0, rd_ff[79:65]});
   end

   function automatic logic [31:0] pack_xy(input logic [16:0] x, input logic [16:0] y);
      pack_xy = {x[15:0], 16'b0} | {{15{y[16]}}, y};
   endfunction

   always_comb begin
      status.cls         = cls;
      status.div_done    = (cnt_ff == '0);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
      status.no_pos      = (sx_ff == -17'sd1) || (sy_ff == -17'sd1);
      status.scan_needed = (down_x_ff == -17'sd1) && (n_eff != 5'd0);
      status.hit         = hit;
      status.scan_last   = ({1'b0, idx_ff} + 5'd1) == n_eff;
      status.discard     = discard_ff;
   end

   // input capture and working payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         type_ff  <= req_ev_type;
         code_ff  <= req_ev_code;
         value_ff <= req_ev_value;
         kidx_ff  <= req_key_index;
         kcode_ff <= req_key_scancode;
         kcx_ff   <= req_key_center_x;
         kcy_ff   <= req_key_center_y;
         kw_ff    <= req_key_width;
         kh_ff    <= req_key_height;
      end
      if (cmd.apply && op_ff) begin
         mem[kidx_ff] <= {kh_ff, kw_ff, kcy_ff, kcx_ff, kcode_ff};
      end
      if (cmd.apply) begin
         px_ff <= sel_st ? st_x_ff : mt_x_ff;
         py_ff <= sel_st ? st_y_ff : mt_y_ff;
         xa_ff <= xa_sel;
         ya_ff <= ya_sel;
         qx_ff <= QuoW'(sel_st ? st_x_ff : mt_x_ff);
         qy_ff <= QuoW'(sel_st ? st_y_ff : mt_y_ff);
         stg_type_ff  <= type_ff;
         stg_code_ff  <= code_ff;
         stg_value_ff <= value_ff;
         if (!is_pass && (code_ff != CODE_MT_SYNC)) begin
            stg_type_ff  <= EV_ABS;
            stg_code_ff  <= OUT_CODE_RELEASE;
            stg_value_ff <= pack_xy(down_x_ff, down_y_ff);
         end
      end
      if (cmd.mul) begin
         prod_ff <= ProdW'(diff_a) * ProdW'(sizem1_a);
         den_ff  <= den_s[17] ? 17'(-den_s) : 17'(den_s);
         qneg_ff <= den_s[17];
      end
      if (cmd.load) begin
         quo_ff  <= prod_ff[ProdW-1] ? ProdW'(-prod_ff) : ProdW'(prod_ff);
         qneg_ff <= qneg_ff ^ prod_ff[ProdW-1];
         rem_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= tge ? (trial - {1'b0, den_ff}) : trial;
         quo_ff <= {quo_ff[ProdW-2:0], tge};
      end
      if (cmd.store) begin
         if (cmd.axis_y) qy_ff <= qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
         else            qx_ff <= qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      end
      if (cmd.post) begin
         sx_ff <= sx_n;
         sy_ff <= sy_n;
      end
      if (cmd.scan_clear)      idx_ff <= '0;
      else if (cmd.scan_next)  idx_ff <= idx_ff + 4'd1;
      if (cmd.scan_read) rd_ff <= mem[idx_ff];
      if (cmd.key_hit) begin
         stg_type_ff  <= EV_KEY;
         stg_code_ff  <= rd_ff[15:0];
         stg_value_ff <= 32'd1;
      end
      if (cmd.take_pos) begin
         stg_type_ff  <= EV_ABS;
         stg_code_ff  <= OUT_CODE_POS;
         stg_value_ff <= pack_xy(sx_ff, sy_ff);
      end
      if (cmd.emit) begin
         rsp_type_ff  <= stg_type_ff;
         rsp_code_ff  <= stg_code_ff;
         rsp_value_ff <= stg_value_ff;
      end
      if (reset) begin
         st_x_ff <= '0;
         st_y_ff <= '0;
         mt_x_ff <= '0;
         mt_y_ff <= '0;
      end else if (cmd.apply && !op_ff && !ignored_ff && is_abs) begin
         if (code_ff == CODE_ABS_X) st_x_ff <= value_ff;
         if (code_ff == CODE_ABS_Y) st_y_ff <= value_ff;
         if (slot_zero_ff && (code_ff == CODE_MT_X)) mt_x_ff <= value_ff;
         if (slot_zero_ff && (code_ff == CODE_MT_Y)) mt_y_ff <= value_ff;
         if (slot_zero_ff && (value_ff == 32'sd0) &&
             ((code_ff == CODE_TOUCH_MJ) || (code_ff == CODE_PRESSURE))) begin
            mt_x_ff <= '0;
            mt_y_ff <= '0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ignored_ff   <= 1'b0;
         discard_ff   <= 1'b0;
         lwr_ff       <= 1'b0;
         rp_ff        <= 1'b0;
         st_any_ff    <= 1'b0;
         mt_any_ff    <= 1'b0;
         slot_zero_ff <= 1'b1;
         down_x_ff    <= -17'sd1;
         down_y_ff    <= -17'sd1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.apply && !op_ff && !ignored_ff) begin
            if (t2c2) begin
               ignored_ff <= 1'b1;
            end else if (t1v0) begin
               ignored_ff <= 1'b0;
            end else if (is_abs) begin
               case (code_ff)
                  CODE_ABS_X: begin
                     st_any_ff <= 1'b1;
                     lwr_ff    <= 1'b0;
                  end
                  CODE_ABS_Y: begin
                     st_any_ff <= 1'b1;
                     lwr_ff    <= 1'b0;
                  end
                  CODE_MT_SLOT: begin
                     slot_zero_ff <= (value_ff == 32'sd0);
                     lwr_ff       <= 1'b0;
                  end
                  CODE_MT_X, CODE_MT_Y: begin
                     if (slot_zero_ff) mt_any_ff <= 1'b1;
                     lwr_ff <= 1'b0;
                  end
                  CODE_TOUCH_MJ, CODE_PRESSURE: begin
                     if (slot_zero_ff && (value_ff == 32'sd0)) rp_ff <= 1'b1;
                     lwr_ff <= 1'b0;
                  end
                  default: lwr_ff <= lwr_ff;
               endcase
            end else if (is_pass) begin
               lwr_ff <= 1'b0;
            end else if (code_ff == CODE_MT_SYNC) begin
               lwr_ff <= lwr_ff;
            end else if (lwr_ff || rp_ff) begin
               rp_ff      <= 1'b0;
               down_x_ff  <= -17'sd1;
               down_y_ff  <= -17'sd1;
               discard_ff <= 1'b0;
            end else begin
               lwr_ff <= 1'b1;
               if (st_any_ff || mt_any_ff) begin
                  st_any_ff    <= 1'b0;
                  mt_any_ff    <= 1'b0;
                  slot_zero_ff <= 1'b1;
               end
            end
         end
         if (cmd.load)          cnt_ff <= DivCntW'(ProdW);
         else if (cmd.div_step) cnt_ff <= cnt_ff - 1'b1;
         if (cmd.key_hit) begin
            discard_ff <= 1'b1;
            down_x_ff  <= 17'sd0;
         end
         if (cmd.take_pos) begin
            down_x_ff <= sx_ff;
            down_y_ff <= sy_ff;
         end
         if (cmd.emit)          rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)   rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_type  = rsp_type_ff;
   assign rsp_out_code  = rsp_code_ff;
   assign rsp_out_value = rsp_value_ff;
endmodule
`default_nettype wire

// File: rtl/touch_event_to_key_translator.sv
// Top level: register file, sequencer and datapath of the touch event translator.
//
// Input words arrive on req_valid/req_stall with one port per field; result
// words leave on rsp_valid/rsp_stall. Each input word yields zero or one
// result word. Registers are written through the APB-style port at byte
// address 4*i and read back with their stored value.
// Only one word is in flight: req_stall is high from the cycle after accept
// until the sequencer is back at idle. A report that is scaled runs one
// shared multiplier and a one-bit-per-cycle divider per axis; a virtual key
// scan reads at most 16 table entries. Reports with either axis minimum
// equal to its maximum skip the multiplier and the divider.
// The result sits in an output register; the next word is accepted while it
// waits. If rsp_stall holds that register, the following result waits in its
// emit step until the register frees.
// Synchronous reset clears all control state and restores register defaults;
// the virtual key table holds unknown contents until written.
`default_nettype none
module touch_event_to_key_translator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_op,
   input  wire logic [15:0]        req_ev_type,
   input  wire logic [15:0]        req_ev_code,
   input  wire logic signed [31:0] req_ev_value,
   input  wire logic [3:0]         req_key_index,
   input  wire logic [15:0]        req_key_scancode,
   input  wire logic [15:0]        req_key_center_x,
   input  wire logic [15:0]        req_key_center_y,
   input  wire logic [15:0]        req_key_width,
   input  wire logic [15:0]        req_key_height,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [15:0]             rsp_out_type,
   output logic [15:0]             rsp_out_code,
   output logic signed [31:0]      rsp_out_value,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import tek_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   logic [2:0] ridx;

   assign pready = 1'b1;
   assign ridx   = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.st_x_axis     <= '0;
         cfg_ff.st_y_axis     <= '0;
         cfg_ff.mt_x_axis     <= '0;
         cfg_ff.mt_y_axis     <= '0;
         cfg_ff.screen_width  <= 13'd320;
         cfg_ff.screen_height <= 13'd480;
         cfg_ff.orient_mode   <= '0;
         cfg_ff.key_count     <= '0;
      end else if (psel && penable && pwrite) begin
         case (ridx)
            REG_ST_X:   cfg_ff.st_x_axis     <= pwdata;
            REG_ST_Y:   cfg_ff.st_y_axis     <= pwdata;
            REG_MT_X:   cfg_ff.mt_x_axis     <= pwdata;
            REG_MT_Y:   cfg_ff.mt_y_axis     <= pwdata;
            REG_WIDTH:  cfg_ff.screen_width  <= pwdata[12:0];
            REG_HEIGHT: cfg_ff.screen_height <= pwdata[12:0];
            REG_ORIENT: cfg_ff.orient_mode   <= pwdata[2:0];
            REG_KEYS:   cfg_ff.key_count     <= pwdata[4:0];
            default:    cfg_ff.key_count     <= cfg_ff.key_count;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_ST_X:   prdata = cfg_ff.st_x_axis;
         REG_ST_Y:   prdata = cfg_ff.st_y_axis;
         REG_MT_X:   prdata = cfg_ff.mt_x_axis;
         REG_MT_Y:   prdata = cfg_ff.mt_y_axis;
         REG_WIDTH:  prdata = {19'b0, cfg_ff.screen_width};
         REG_HEIGHT: prdata = {19'b0, cfg_ff.screen_height};
         REG_ORIENT: prdata = {29'b0, cfg_ff.orient_mode};
         REG_KEYS:   prdata = {27'b0, cfg_ff.key_count};
         default:    prdata = '0;
      endcase
   end

   tek_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tek_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_ev_type      (req_ev_type),
      .req_ev_code      (req_ev_code),
      .req_ev_value     (req_ev_value),
      .req_key_index    (req_key_index),
      .req_key_scancode (req_key_scancode),
      .req_key_center_x (req_key_center_x),
      .req_key_center_y (req_key_center_y),
      .req_key_width    (req_key_width),
      .req_key_height   (req_key_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_code     (rsp_out_code),
      .rsp_out_value    (rsp_out_value)
   );
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the touch event to key translator.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tek_pkg::*;

   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_KEY_WRITE = 1'b1;
   localparam logic [15:0] EV_OTHER = 16'h0004;
   localparam logic [15:0] CODE_ABS_MISC = 16'h0010;
   localparam int CHK_MODEL = 0;
   localparam int CHK_NONE = 1;
   localparam int CHK_ONE = 2;
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      logic        op;
      logic [15:0] ev_type;
      logic [15:0] ev_code;
      logic [31:0] ev_value;
      logic [3:0]  kidx;
      logic [15:0] ksc, kcx, kcy, kw, kh;
   } word_type;

   typedef struct {
      logic [15:0] ev_type;
      logic [15:0] ev_code;
      logic [31:0] ev_value;
   } touch_ev_type;

   typedef struct {
      word_type     w;
      int           chk;
      touch_ev_type ev;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [15:0] req_ev_type = '0, req_ev_code = '0;
   logic signed [31:0] req_ev_value = '0;
   logic [3:0] req_key_index = '0;
   logic [15:0] req_key_scancode = '0, req_key_center_x = '0, req_key_center_y = '0;
   logic [15:0] req_key_width = '0, req_key_height = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_out_type, rsp_out_code;
   logic signed [31:0] rsp_out_value;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   touch_event_to_key_translator uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   cfg_type cfg;
   bit ignored, discard, last_rpt, rel_pending;
   int down_x, down_y, st_x, st_y, mt_x, mt_y, mt_slot;
   bit [1:0] st_seen, mt_seen;
   logic [15:0] key_code [MaxKeys];
   logic [31:0] key_ctr [MaxKeys];
   logic [31:0] key_size [MaxKeys];

   touch_ev_type pending_events[$];
   row_type directed_rows[$];
   int errors = 0;
   bit idle_on = 1'b1;
   int stall_left = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic longint scale_axis(input longint pos, input logic [31:0] ax,
                                         input logic [12:0] size);
      longint lo, hi;
      lo = longint'($signed(ax[15:0]));
      hi = longint'($signed(ax[31:16]));
      return (pos - lo) * (longint'(size) - 1) / (hi - lo);
   endfunction

   function automatic int sat17(input longint v);
      if (v < -65536) return -65536;
      if (v > 65535) return 65535;
      return int'(v);
   endfunction

   function automatic logic [31:0] pack_xy(input int x, input int y);
      return (32'(x) << 16) | 32'(y);
   endfunction

   function automatic longint absdiff(input longint a, input longint b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic bit translate_word(input word_type w, output touch_ev_type r);
      int value;
      longint px, py, x, y, t;
      logic [31:0] xa, ya;
      logic [12:0] fw, fh;
      int sx, sy, n;
      value = int'($signed(w.ev_value));
      r = '{w.ev_type, w.ev_code, w.ev_value};
      if (w.op == OP_KEY_WRITE) begin
         key_code[w.kidx] = w.ksc;
         key_ctr[w.kidx] = {w.kcy, w.kcx};
         key_size[w.kidx] = {w.kh, w.kw};
         return 0;
      end
      if (ignored) return 0;
      if (w.ev_type == EV_REL && w.ev_code == CODE_REL_Z) begin
         ignored = 1;
         return 0;
      end
      if (w.ev_type == EV_KEY && value == 0) return 0;
      if (w.ev_type == EV_ABS) begin
         case (w.ev_code)
            CODE_ABS_X: begin st_seen[0] = 1; st_x = value; end
            CODE_ABS_Y: begin st_seen[1] = 1; st_y = value; end
            CODE_MT_SLOT: mt_slot = value;
            CODE_MT_X: if (mt_slot == 0) begin mt_seen[0] = 1; mt_x = value; end
            CODE_MT_Y: if (mt_slot == 0) begin mt_seen[1] = 1; mt_y = value; end
            CODE_TOUCH_MJ, CODE_PRESSURE: if (mt_slot == 0 && value == 0) begin
               mt_x = 0;
               mt_y = 0;
               rel_pending = 1;
            end
            default: return 0;
         endcase
         last_rpt = 0;
         return 0;
      end
      if (w.ev_code != CODE_ALT_RPT &&
          (w.ev_type != EV_SYN || (w.ev_code != CODE_REPORT && w.ev_code != CODE_MT_SYNC))) begin
         last_rpt = 0;
         return 1;
      end
      if (w.ev_code == CODE_MT_SYNC) return 1;
      if (last_rpt || rel_pending) begin
         bit hit_out;
         hit_out = !discard;
         r = '{EV_ABS, OUT_CODE_RELEASE, pack_xy(down_x, down_y)};
         rel_pending = 0;
         down_x = -1;
         down_y = -1;
         discard = 0;
         return hit_out;
      end
      last_rpt = 1;
      if (st_seen != 0) begin
         px = st_x; py = st_y; xa = cfg.st_x_axis; ya = cfg.st_y_axis;
      end else if (mt_seen != 0) begin
         px = mt_x; py = mt_y; xa = cfg.mt_x_axis; ya = cfg.mt_y_axis;
      end else begin
         return 0;
      end
      if (xa[15:0] == xa[31:16] || ya[15:0] == ya[31:16]) begin
         x = px;
         y = py;
      end else begin
         fw = cfg.orient_mode[0] ? cfg.screen_height : cfg.screen_width;
         fh = cfg.orient_mode[0] ? cfg.screen_width : cfg.screen_height;
         x = scale_axis(px, xa, fw);
         y = scale_axis(py, ya, fh);
      end
      if (cfg.orient_mode[0]) begin t = x; x = y; y = t; end
      if (cfg.orient_mode[1]) x = longint'(cfg.screen_width) - x;
      if (cfg.orient_mode[2]) y = longint'(cfg.screen_height) - y;
      sx = sat17(x);
      sy = sat17(y);
      st_seen = 0;
      mt_seen = 0;
      mt_slot = 0;
      if (sx == -1 || sy == -1) return 0;
      if (down_x == -1) begin
         n = cfg.key_count < MaxKeys ? int'(cfg.key_count) : MaxKeys;
         for (int i = 0; i < n; i++) begin
            if (absdiff(longint'(key_ctr[i][15:0]), sx) < longint'(key_size[i][15:1]) &&
                absdiff(longint'(key_ctr[i][31:16]), sy) < longint'(key_size[i][31:17])) begin
               discard = 1;
               down_x = 0;
               r = '{EV_KEY, key_code[i], 32'd1};
               return 1;
            end
         end
      end
      if (discard) return 0;
      down_x = sx;
      down_y = sy;
      r = '{EV_ABS, OUT_CODE_POS, pack_xy(sx, sy)};
      return 1;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = data;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      case (idx)
         REG_ST_X:   cfg.st_x_axis = data;
         REG_ST_Y:   cfg.st_y_axis = data;
         REG_MT_X:   cfg.mt_x_axis = data;
         REG_MT_Y:   cfg.mt_y_axis = data;
         REG_WIDTH:  cfg.screen_width = data[12:0];
         REG_HEIGHT: cfg.screen_height = data[12:0];
         REG_ORIENT: cfg.orient_mode = data[2:0];
         REG_KEYS:   cfg.key_count = data[4:0];
         default: ;
      endcase
   endtask

   // drive one word at the falling edge and hold it until accepted
   task automatic send_word(input word_type w, input int chk, input touch_ev_type typed);
      touch_ev_type r;
      bit got;
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_op = w.op; req_ev_type = w.ev_type; req_ev_code = w.ev_code;
      req_ev_value = w.ev_value; req_key_index = w.kidx; req_key_scancode = w.ksc;
      req_key_center_x = w.kcx; req_key_center_y = w.kcy;
      req_key_width = w.kw; req_key_height = w.kh;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      got = translate_word(w, r);
      if (chk == CHK_ONE) pending_events.push_back(typed);
      else if (chk == CHK_MODEL && got) pending_events.push_back(r);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic word_type ev_word(input logic [15:0] t, input logic [15:0] c,
                                        input logic [31:0] v);
      word_type w;
      w = '{OP_EVENT, t, c, v, 4'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom)};
      return w;
   endfunction

   function automatic word_type key_word(input logic [3:0] i, input logic [15:0] sc,
                                         input logic [15:0] cx, input logic [15:0] cy,
                                         input logic [15:0] kw, input logic [15:0] kh);
      word_type w;
      w = '{OP_KEY_WRITE, 16'($urandom), 16'($urandom), $urandom, i, sc, cx, cy, kw, kh};
      return w;
   endfunction

   function automatic word_type random_key();
      return key_word(4'($urandom), 16'($urandom), 16'($urandom_range(0, 4200)),
                      16'($urandom_range(0, 4200)), 16'($urandom_range(0, 800)),
                      16'($urandom_range(0, 800)));
   endfunction

   task automatic add_row(input word_type w, input int chk, input touch_ev_type ev);
      row_type row;
      row = '{w, chk, ev};
      directed_rows.push_back(row);
   endtask

   function automatic logic [31:0] pick_axis();
      logic [15:0] lo, hi;
      case ($urandom_range(0, 5))
         0: begin lo = 16'($urandom); hi = lo; end
         1: begin lo = 0; hi = 4095; end
         2: begin lo = -16'sd2000; hi = 16'sd2000; end
         3: begin lo = 4095; hi = 0; end
         4: begin lo = 16'h8000; hi = 16'h7fff; end
         default: begin lo = 16'($urandom); hi = 16'($urandom); end
      endcase
      return {hi, lo};
   endfunction

   function automatic logic [31:0] pick_pos();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'hffffffff;
         2: return 32'($urandom_range(0, 70000)) - 32'd2500;
         default: return 32'($urandom_range(0, 4200)) - 32'd100;
      endcase
   endfunction

   // one touch frame, or a single noise word
   task automatic random_burst(inout int count);
      word_type q[$];
      touch_ev_type none;
      logic [15:0] t, c;
      none = '{16'h0, 16'h0, 32'h0};
      if ($urandom_range(0, 9) < 7) begin
         if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 3) == 0) q.push_back(ev_word(EV_ABS, CODE_MT_SLOT,
                                                               $urandom_range(0, 2)));
            q.push_back(ev_word(EV_ABS, CODE_MT_X, pick_pos()));
            q.push_back(ev_word(EV_ABS, CODE_MT_Y, pick_pos()));
         end else begin
            q.push_back(ev_word(EV_ABS, CODE_ABS_X, pick_pos()));
            if ($urandom_range(0, 7) != 0) q.push_back(ev_word(EV_ABS, CODE_ABS_Y, pick_pos()));
         end
         if ($urandom_range(0, 5) == 0)
            q.push_back(ev_word(EV_ABS, $urandom_range(0, 1) ? CODE_PRESSURE : CODE_TOUCH_MJ,
                                $urandom_range(0, 1) ? 32'd0 : $urandom));
         if ($urandom_range(0, 7) == 0) q.push_back(ev_word(EV_SYN, CODE_MT_SYNC, $urandom));
         q.push_back(ev_word($urandom_range(0, 5) == 0 ? EV_KEY : EV_SYN,
                             $urandom_range(0, 5) == 0 ? CODE_ALT_RPT : CODE_REPORT,
                             $urandom));
         if ($urandom_range(0, 2) == 0) q.push_back(ev_word(EV_SYN, CODE_REPORT, 0));
      end else begin
         case ($urandom_range(0, 4))
            0: q.push_back(random_key());
            1: q.push_back(ev_word(EV_KEY, 16'($urandom), $urandom_range(0, 1) ? 0 : $urandom));
            2: q.push_back(ev_word(EV_ABS, 16'($urandom), $urandom));
            default: begin
               t = 16'($urandom);
               c = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom);
               if (t == EV_REL && c == CODE_REL_Z) c = CODE_REPORT;
               q.push_back(ev_word(t, c, $urandom));
            end
         endcase
      end
      foreach (q[i]) send_word(q[i], CHK_MODEL, none);
      count += q.size();
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1;
         stall_left--;
      end else begin
         rsp_stall = 0;
      end
   end

   always @(posedge clock) begin
      touch_ev_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = idle_on ? $urandom_range(0, 5) : 0;
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h %h %h",
                                      rsp_out_type, rsp_out_code, rsp_out_value));
         end else begin
            e = pending_events.pop_front();
            if (rsp_out_type !== e.ev_type)
               report_mismatch($sformatf("type %h, want %h", rsp_out_type, e.ev_type));
            if (rsp_out_code !== e.ev_code)
               report_mismatch($sformatf("code %h, want %h", rsp_out_code, e.ev_code));
            if (rsp_out_value !== e.ev_value)
               report_mismatch($sformatf("value %h, want %h", rsp_out_value, e.ev_value));
         end
      end
   end

   initial begin
      #60000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      touch_ev_type none;
      int count;
      none = '{16'h0, 16'h0, 32'h0};
      cfg = '{32'h0, 32'h0, 32'h0, 32'h0, 13'd320, 13'd480, 3'd0, 5'd0};
      ignored = 0; discard = 0; last_rpt = 0; rel_pending = 0;
      down_x = -1; down_y = -1;
      st_x = 0; st_y = 0; mt_x = 0; mt_y = 0; mt_slot = 0;
      st_seen = 0; mt_seen = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (int i = 0; i < MaxKeys; i++) begin
         word_type w;
         w = random_key();
         w.kidx = 4'(i);
         send_word(w, CHK_MODEL, none);
      end
      settle();
      csr_write(REG_KEYS, 32'd1);

      add_row(ev_word(16'hffff, 16'hffff, 32'h80000000), CHK_ONE,
              '{16'hffff, 16'hffff, 32'h80000000});
      add_row(ev_word(EV_OTHER, CODE_REPORT, 32'h7fffffff), CHK_ONE,
              '{EV_OTHER, CODE_REPORT, 32'h7fffffff});
      add_row(ev_word(EV_KEY, 16'd30, 32'd0), CHK_NONE, none);
      add_row(ev_word(EV_KEY, 16'd30, 32'd1), CHK_ONE, '{EV_KEY, 16'd30, 32'd1});
      add_row(ev_word(EV_SYN, CODE_MT_SYNC, 32'd7), CHK_ONE, '{EV_SYN, CODE_MT_SYNC, 32'd7});
      add_row(key_word(4'd0, 16'hffff, 16'd50, 16'd60, 16'd20, 16'd20), CHK_NONE, none);
      add_row(key_word(4'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff),
              CHK_NONE, none);
      add_row(ev_word(EV_ABS, CODE_ABS_X, 32'd100), CHK_NONE, none);
      add_row(ev_word(EV_ABS, CODE_ABS_Y, 32'd200), CHK_NONE, none);
      add_row(ev_word(EV_SYN, CODE_REPORT, 32'd0), CHK_MODEL, none);
      add_row(ev_word(EV_SYN, CODE_REPORT, 32'd0), CHK_MODEL, none);
      add_row(ev_word(EV_ABS, CODE_MT_SLOT, 32'd1), CHK_NONE, none);
      add_row(ev_word(EV_ABS, CODE_MT_X, 32'd9), CHK_NONE, none);
      add_row(ev_word(EV_ABS, CODE_MT_SLOT, 32'd0), CHK_NONE, none);
      add_row(ev_word(EV_ABS, CODE_MT_X, 32'd50), CHK_NONE, none);
      add_row(ev_word(EV_ABS, CODE_MT_Y, 32'd60), CHK_NONE, none);
      add_row(ev_word(EV_SYN, CODE_REPORT, 32'd0), CHK_ONE, '{EV_KEY, 16'hffff, 32'd1});
      add_row(ev_word(EV_ABS, CODE_PRESSURE, 32'd0), CHK_NONE, none);
      add_row(ev_word(EV_SYN, CODE_REPORT, 32'd0), CHK_MODEL, none);
      add_row(ev_word(EV_ABS, CODE_TOUCH_MJ, 32'd0), CHK_NONE, none);
      add_row(ev_word(EV_KEY, CODE_ALT_RPT, 32'd5), CHK_MODEL, none);
      add_row(ev_word(EV_ABS, CODE_ABS_MISC, 32'd3), CHK_NONE, none);
      add_row(ev_word(EV_ABS, CODE_ABS_X, 32'hffffffff), CHK_NONE, none);
      add_row(ev_word(EV_ABS, CODE_ABS_Y, 32'hffffffff), CHK_NONE, none);
      add_row(ev_word(EV_SYN, CODE_REPORT, 32'd0), CHK_MODEL, none);
      foreach (directed_rows[i])
         send_word(directed_rows[i].w, directed_rows[i].chk, directed_rows[i].ev);
      settle();

      for (int ph = 0; ph < 7; ph++) begin
         logic [31:0] ax [4];
         foreach (ax[k]) ax[k] = pick_axis();
         case (ph)
            0: begin ax[0] = 32'h0; ax[1] = 32'hffffffff; end
            1: begin ax[0] = 32'hffffffff; ax[2] = 32'h0; end
            default: ;
         endcase
         csr_write(REG_ST_X, ax[0]);
         csr_write(REG_ST_Y, ax[1]);
         csr_write(REG_MT_X, ax[2]);
         csr_write(REG_MT_Y, ax[3]);
         csr_write(REG_WIDTH, ph == 1 ? 32'd1 : ph == 2 ? 32'd4096 : $urandom_range(1, 4096));
         csr_write(REG_HEIGHT, ph == 1 ? 32'd1 : ph == 2 ? 32'd4096 : $urandom_range(1, 4096));
         csr_write(REG_ORIENT, ph == 2 ? 32'd7 : ph == 0 ? 32'd0 : $urandom_range(0, 7));
         csr_write(REG_KEYS, ph == 1 ? 32'd0 : ph == 2 ? 32'd16 : $urandom_range(0, 16));
         idle_on = (ph != 3);
         count = 0;
         while (count < 260) random_burst(count);
         settle();
      end

      idle_on = 1;
      send_word(ev_word(EV_REL, CODE_REL_Z, 32'd1), CHK_NONE, none);
      for (int i = 0; i < 6; i++) send_word(ev_word(EV_OTHER, 16'd3, $urandom), CHK_NONE, none);
      send_word(ev_word(EV_SYN, CODE_REPORT, 32'd0), CHK_NONE, none);
      settle();

      if (pending_events.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", pending_events.size()));
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
